### hw/rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Types, constants and the reply frame builder shared by the ARP responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [15:0] OP_REQUEST    = 16'd1;
  localparam logic [15:0] OP_REPLY      = 16'd2;
  localparam logic [7:0]  HW_ADDR_LEN   = 8'd6;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
  localparam logic [47:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;

  // byte index of the last ARP header byte (end of target IP)
  localparam logic [5:0]  HDR_LAST_POS  = 6'd41;
  localparam logic [5:0]  POS_MAX       = 6'd63;
  localparam int          HDR_BYTES     = 42;

  localparam logic [31:0] OWN_IP_RESET  = 32'd167772687;

  // register indexes (selected by paddr[3])
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  // one command from the front end to the emitter
  typedef struct packed {
    logic        is_reply;   // 1: emit a reply frame, 0: emit a resolve answer
    logic [15:0] hw_type;
    logic [15:0] ptype;
    logic [47:0] mac;        // requester MAC, or resolve MAC
    logic [31:0] ip;         // requester IP
    logic        hit;        // resolve hit
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  // byte idx of the reply frame; zero padding past the ARP header
  function automatic logic [7:0] frame_byte(input logic [5:0] idx, input cmd_t c,
                                            input logic [47:0] own_mac,
                                            input logic [31:0] own_ip);
    logic [HDR_BYTES*8-1:0] f;
    logic [7:0]             b;
    f = {c.mac, own_mac, ETHERTYPE_ARP, c.hw_type, c.ptype,
         HW_ADDR_LEN, PROTO_ADDR_LEN, OP_REPLY, own_mac, own_ip, c.mac, c.ip};
    b = 8'd0;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (idx == 6'(i)) begin
        b = f[HDR_BYTES*8-1-8*i -: 8];
      end
    end
    return b;
  endfunction

endpackage

### hw/rtl/arpc_intf.sv
// ----------------------------------------------------------------------------
// arpc channel interfaces
// Request channel (frame bytes and resolve queries) and result channel.
// ----------------------------------------------------------------------------
interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  rx_byte;
  logic        rx_end;
  logic [31:0] query_ip;

  modport source(output valid, func, rx_byte, rx_end, query_ip, input ready);
  modport sink(input valid, func, rx_byte, rx_end, query_ip, output ready);
endinterface

interface arpc_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        tx_end;
  logic        resolve_hit;
  logic [47:0] resolve_mac;

  modport source(output valid, kind, tx_byte, tx_end, resolve_hit, resolve_mac,
                 input ready);
  modport sink(input valid, kind, tx_byte, tx_end, resolve_hit, resolve_mac,
               output ready);
endinterface

### hw/rtl/arpc_front.sv
// ----------------------------------------------------------------------------
// arpc_front
// Accepts requests, captures ARP header fields, keeps the one-entry cache
// and pushes reply / resolve commands toward the emitter.
// ----------------------------------------------------------------------------
module arpc_front (
  input  logic               clk,
  input  logic               rst,
  arpc_req_if.sink           req,
  input  logic [31:0]        own_ip,
  input  logic               q_full,
  output arpc_pkg::cmd_slot_t push
);

  logic [5:0]  pos, pos_next;
  logic [15:0] ethertype, ethertype_next;
  logic [15:0] hw_type, hw_type_next;
  logic [15:0] ptype, ptype_next;
  logic [15:0] opcode, opcode_next;
  logic [47:0] src_mac, src_mac_next;
  logic [31:0] src_ip, src_ip_next;
  logic [31:0] tgt_ip, tgt_ip_next;
  logic [31:0] cached_ip;
  logic [47:0] cached_mac;
  logic        cache_valid;

  logic acc, byte_acc, frame_hit, hit;

  assign req.ready = !q_full;
  assign acc       = req.valid && req.ready;
  assign byte_acc  = acc && !req.func;

  always_comb begin
    ethertype_next = ethertype;
    hw_type_next   = hw_type;
    ptype_next     = ptype;
    opcode_next    = opcode;
    src_mac_next   = src_mac;
    src_ip_next    = src_ip;
    tgt_ip_next    = tgt_ip;
    pos_next       = pos;
    if (byte_acc) begin
      case (pos) inside
        [6'd12:6'd13]: ethertype_next = {ethertype[7:0], req.rx_byte};
        [6'd14:6'd15]: hw_type_next   = {hw_type[7:0], req.rx_byte};
        [6'd16:6'd17]: ptype_next     = {ptype[7:0], req.rx_byte};
        [6'd20:6'd21]: opcode_next    = {opcode[7:0], req.rx_byte};
        [6'd22:6'd27]: src_mac_next   = {src_mac[39:0], req.rx_byte};
        [6'd28:6'd31]: src_ip_next    = {src_ip[23:0], req.rx_byte};
        [6'd38:6'd41]: tgt_ip_next    = {tgt_ip[23:0], req.rx_byte};
        default: ;
      endcase
      if (req.rx_end) begin
        pos_next = 6'd0;
      end else if (pos != arpc_pkg::POS_MAX) begin
        pos_next = pos + 6'd1;
      end
    end
  end

  // ARP frame of full length addressed to us
  assign frame_hit = byte_acc && req.rx_end && (pos >= arpc_pkg::HDR_LAST_POS) &&
                     (ethertype_next == arpc_pkg::ETHERTYPE_ARP) &&
                     (tgt_ip_next == own_ip);

  assign hit = cache_valid && (cached_ip == req.query_ip);

  always_comb begin
    push.valid          = 1'b0;
    push.cmd.is_reply   = 1'b0;
    push.cmd.hw_type    = hw_type_next;
    push.cmd.ptype      = ptype_next;
    push.cmd.mac        = src_mac_next;
    push.cmd.ip         = src_ip_next;
    push.cmd.hit        = 1'b0;
    if (acc && req.func) begin
      push.valid   = 1'b1;
      push.cmd.hit = hit;
      push.cmd.mac = hit ? cached_mac : arpc_pkg::BCAST_MAC;
    end else if (frame_hit && (opcode_next == arpc_pkg::OP_REQUEST)) begin
      push.valid        = 1'b1;
      push.cmd.is_reply = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      ethertype   <= '0;
      hw_type     <= '0;
      ptype       <= '0;
      opcode      <= '0;
      src_mac     <= '0;
      src_ip      <= '0;
      tgt_ip      <= '0;
      cached_ip   <= '0;
      cached_mac  <= '0;
      cache_valid <= 1'b0;
    end else begin
      pos       <= pos_next;
      ethertype <= ethertype_next;
      hw_type   <= hw_type_next;
      ptype     <= ptype_next;
      opcode    <= opcode_next;
      src_mac   <= src_mac_next;
      src_ip    <= src_ip_next;
      tgt_ip    <= tgt_ip_next;
      if (frame_hit && (opcode_next == arpc_pkg::OP_REPLY)) begin
        cached_ip   <= src_ip_next;
        cached_mac  <= src_mac_next;
        cache_valid <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/arpc_queue.sv
// ----------------------------------------------------------------------------
// arpc_queue
// Small FIFO of commands between the front end and the emitter.
// ----------------------------------------------------------------------------
module arpc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  arpc_pkg::cmd_slot_t push,
  output logic                full,
  output arpc_pkg::cmd_slot_t head,
  input  logic                pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  arpc_pkg::cmd_t  mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### hw/rtl/arpc_back.sv
// ----------------------------------------------------------------------------
// arpc_back
// Emitter: turns each queued command into reply frame bytes or one resolve
// answer, through a registered result stage.
// ----------------------------------------------------------------------------
module arpc_back #(
  parameter int REPLY_FRAME_BYTES = 60
) (
  input  logic                clk,
  input  logic                rst,
  input  arpc_pkg::cmd_slot_t head,
  output logic                pop,
  input  logic [47:0]         own_mac,
  input  logic [31:0]         own_ip,
  arpc_rsp_if.source          rsp
);

  localparam logic [5:0] LAST_IDX = 6'(REPLY_FRAME_BYTES - 1);

  logic [5:0] idx;
  logic       load, last_byte;

  assign load      = head.valid && (!rsp.valid || rsp.ready);
  assign last_byte = (idx == LAST_IDX);
  assign pop       = load && (!head.cmd.is_reply || last_byte);

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.kind <= !head.cmd.is_reply;
      if (head.cmd.is_reply) begin
        rsp.tx_byte     <= arpc_pkg::frame_byte(idx, head.cmd, own_mac, own_ip);
        rsp.tx_end      <= last_byte;
        rsp.resolve_hit <= 1'b0;
        rsp.resolve_mac <= '0;
      end else begin
        rsp.tx_byte     <= '0;
        rsp.tx_end      <= 1'b0;
        rsp.resolve_hit <= head.cmd.hit;
        rsp.resolve_mac <= head.cmd.mac;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (load && head.cmd.is_reply) begin
        idx <= last_byte ? 6'd0 : idx + 6'd1;
      end
    end
  end

endmodule

### hw/rtl/arp_responder_with_cache.sv
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// ARP responder with a one-entry address cache and an APB register port.
// ----------------------------------------------------------------------------
// Path: a resolve answer, or the first reply byte, is written to the queue when
//   its request is accepted and is then registered out through the result stage.
// Throughput: one request per cycle; a reply frame drains at one byte per cycle
//   while rsp is not back-pressured; requests stall only when the queue is full.
// Reset: synchronous rst empties the capture state, cache, queue and result
//   stage; own_ip resets to 10.0.2.15, own_mac to zero.
module arp_responder_with_cache #(
  parameter int REPLY_FRAME_BYTES = 60,   // 42..64
  parameter int QUEUE_DEPTH       = 4
) (
  input  logic        clk,
  input  logic        rst,
  arpc_req_if.sink    req,
  arpc_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. Registers sit 8 bytes apart, so paddr[3] picks
  // one; the low address bits are not decoded.
  // --------------------------------------------------------------------------
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= arpc_pkg::OWN_IP_RESET;
      own_mac <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == arpc_pkg::REG_OWN_IP) begin
        own_ip <= pwdata[31:0];
      end else begin
        own_mac <= pwdata[47:0];
      end
    end
  end

  always_comb begin
    case (paddr[3])
      arpc_pkg::REG_OWN_IP:  prdata = {32'd0, own_ip};
      arpc_pkg::REG_OWN_MAC: prdata = {16'd0, own_mac};
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front end: parses frame bytes, updates the cache and answers resolve
  // lookups at accept time, so cache state is seen in request order.
  // Each reply or answer becomes one command carrying its own snapshot of
  // the captured fields; later frames may overwrite the capture freely.
  // --------------------------------------------------------------------------
  arpc_pkg::cmd_slot_t push, head;
  logic                q_full, pop;

  arpc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .own_ip (own_ip),
    .q_full (q_full),
    .push   (push)
  );

  // Command queue decouples the byte-rate front end from the reply emitter.
  arpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  // Back end: expands a reply command into the full padded frame, one byte
  // per cycle unless rsp back-pressures, or emits a resolve answer in a single result.
  arpc_back #(
    .REPLY_FRAME_BYTES (REPLY_FRAME_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .own_mac (own_mac),
    .own_ip  (own_ip),
    .rsp     (rsp)
  );

endmodule
